FILE: src/assert_macros.svh
// Assertion macros used by the checker of the date converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define ES_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define ES_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: src/es2cal_pkg.sv
// Types, constants and the month length function of the date converter.
package es2cal_pkg;

    localparam logic [16:0] SECS_PER_DAY    = 17'd86400;
    localparam logic [16:0] SECS_PER_HOUR   = 17'd3600;
    localparam logic [16:0] SECS_PER_MIN    = 17'd60;
    localparam logic [16:0] DAYS_PER_WEEK   = 17'd7;
    localparam logic [15:0] EPOCH_WEEKDAY   = 16'd2;
    localparam logic [11:0] EPOCH_YEAR      = 12'd1980;
    localparam logic [8:0]  EPOCH_MOD400    = 9'd380;
    localparam logic [6:0]  EPOCH_MOD100    = 7'd80;
    localparam logic [8:0]  MOD400_LAST     = 9'd399;
    localparam logic [6:0]  MOD100_LAST     = 7'd99;
    localparam logic [8:0]  DAYS_LEAP_YEAR  = 9'd366;
    localparam logic [8:0]  DAYS_COMMON_YEAR = 9'd365;
    localparam logic [9:0]  MS_PER_SEC      = 10'd1000;

    // Step counter and the last step index of each division phase: one step
    // forms the quotient, the next one the remainder.
    localparam int CNT_W = 1;
    localparam logic [CNT_W-1:0] DAY_LAST  = 1'b1;
    localparam logic [CNT_W-1:0] HOUR_LAST = 1'b1;
    localparam logic [CNT_W-1:0] MIN_LAST  = 1'b1;
    localparam logic [CNT_W-1:0] WDAY_LAST = 1'b1;

    // Rounded-up reciprocals of the odd part of each divisor.
    // Days: (secs >> 7) * ceil(2^35 / 675) >> 35.
    // Hours: (tod >> 4) * ceil(2^21 / 225) >> 21.
    // Minutes: (rest >> 2) * ceil(2^14 / 15) >> 14.
    // Weekday: (days + 2) * ceil(2^19 / 7) >> 19.
    localparam logic [25:0] DAY_RECIP  = 26'd50903317;
    localparam logic [25:0] HOUR_RECIP = 26'd9321;
    localparam logic [25:0] MIN_RECIP  = 26'd1093;
    localparam logic [25:0] WDAY_RECIP = 26'd74899;

    localparam logic [3:0] MONTH_FEB  = 4'd1;
    localparam logic [3:0] MONTH_LAST = 4'd11;

    typedef enum logic [1:0] {
        DIV_DAY,
        DIV_HOUR,
        DIV_MIN,
        DIV_WDAY
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     div_step;
        logic     div_last;
        div_sel_t div_sel;
        logic     year_step;
        logic     month_step;
        logic     finish;
    } cmd_t;

    typedef struct packed {
        logic year_done;
        logic month_done;
    } status_t;

    // Days in a month; idx 0 is January.
    function automatic logic [4:0] month_len(input logic [3:0] idx, input logic leap);
        logic [4:0] len;
        if (idx == MONTH_FEB)
        begin
            len = leap ? 5'd29 : 5'd28;
        end
        else if (idx == 4'd3 || idx == 4'd5 || idx == 4'd8 || idx == 4'd10)
        begin
            len = 5'd30;
        end
        else
        begin
            len = 5'd31;
        end
        return len;
    endfunction

endpackage

FILE: src/epoch_seconds_to_calendar_date.sv
// Top level of the converter from seconds since 1980 to calendar date and time.
//
// Usage: present whole_seconds (seconds since 1980-01-01 00:00:00) and millis_in,
// and raise start. The transaction is accepted at a rising edge where start is
// high and busy is low; busy then stays high until the result is ready.
// The result appears on year, month, day, hour, minute, second_out, millis_out
// and weekday, marked by done for exactly one cycle. The receiver cannot stall
// the block; it must take the result in that cycle. Busy drops in the same
// cycle that done is high, so the next transaction may start right away.
// From acceptance to done the block performs four divisions by constants
// (days, hours, minutes, weekday), each a reciprocal multiply for the quotient
// and a multiply-subtract for the remainder, then a walk over the elapsed years
// and a walk over the elapsed months, each closed by a final step. The year walk
// sets the upper bound on the time to done.
// One transaction is processed at a time.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and clears
// done; a transaction in flight is dropped.
module epoch_seconds_to_calendar_date (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] whole_seconds,
    input  logic [9:0]  millis_in,
    output logic        done,
    output logic [11:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second_out,
    output logic [9:0]  millis_out,
    output logic [2:0]  weekday
);
    import es2cal_pkg::*;

    // Commands from the sequencer and status back from the datapath.
    cmd_t    cmd;
    status_t status;

    es2cal_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // The datapath holds the dividers, the year and month walk, and the
    // result registers, which stay put until the next transaction updates them.
    es2cal_dpath u_dpath (
        .clk           (clk),
        .cmd           (cmd),
        .whole_seconds (whole_seconds),
        .millis_in     (millis_in),
        .status        (status),
        .year          (year),
        .month         (month),
        .day           (day),
        .hour          (hour),
        .minute        (minute),
        .second_out    (second_out),
        .millis_out    (millis_out),
        .weekday       (weekday)
    );

endmodule

FILE: src/es2cal_ctrl.sv
// Sequencer of the date converter: walks the division, year and month phases.
module es2cal_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  es2cal_pkg::status_t status,
    output es2cal_pkg::cmd_t    cmd,
    output logic                busy,
    output logic                done
);
    import es2cal_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DAY,
        S_HOUR,
        S_MIN,
        S_WDAY,
        S_YEAR,
        S_MONTH
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;

    always_comb
    begin
        cmd        = '0;
        cmd.div_sel = DIV_DAY;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DAY;
                    cnt_next   = DAY_LAST;
                end
            end
            S_DAY:
            begin
                cmd.div_step = 1'b1;
                cmd.div_sel  = DIV_DAY;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    cmd.div_last = 1'b1;
                    state_next   = S_HOUR;
                    cnt_next     = HOUR_LAST;
                end
            end
            S_HOUR:
            begin
                cmd.div_step = 1'b1;
                cmd.div_sel  = DIV_HOUR;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    cmd.div_last = 1'b1;
                    state_next   = S_MIN;
                    cnt_next     = MIN_LAST;
                end
            end
            S_MIN:
            begin
                cmd.div_step = 1'b1;
                cmd.div_sel  = DIV_MIN;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    cmd.div_last = 1'b1;
                    state_next   = S_WDAY;
                    cnt_next     = WDAY_LAST;
                end
            end
            S_WDAY:
            begin
                cmd.div_step = 1'b1;
                cmd.div_sel  = DIV_WDAY;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    cmd.div_last = 1'b1;
                    state_next   = S_YEAR;
                end
            end
            S_YEAR:
            begin
                cmd.year_step = 1'b1;
                if (status.year_done)
                begin
                    state_next = S_MONTH;
                end
            end
            S_MONTH:
            begin
                cmd.month_step = 1'b1;
                if (status.month_done)
                begin
                    cmd.finish = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

FILE: src/es2cal_dpath.sv
// Datapath of the date converter: reciprocal dividers and calendar walk.
module es2cal_dpath (
    input  logic                clk,
    input  es2cal_pkg::cmd_t    cmd,
    input  logic [31:0]         whole_seconds,
    input  logic [9:0]          millis_in,
    output es2cal_pkg::status_t status,
    output logic [11:0]         year,
    output logic [3:0]          month,
    output logic [4:0]          day,
    output logic [4:0]          hour,
    output logic [5:0]          minute,
    output logic [5:0]          second_out,
    output logic [9:0]          millis_out,
    output logic [2:0]          weekday
);
    import es2cal_pkg::*;

    logic [31:0] rem_reg, rem_next;
    logic [15:0] quo_reg, quo_next;
    logic [15:0] days_reg, days_next;
    logic [15:0] cday_reg, cday_next;
    logic [11:0] year_reg, year_next;
    logic [8:0]  mod400_reg, mod400_next;
    logic [6:0]  mod100_reg, mod100_next;
    logic [3:0]  mon_idx_reg, mon_idx_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  min_reg, min_next;
    logic [5:0]  sec_reg, sec_next;
    logic [9:0]  ms_reg, ms_next;
    logic [2:0]  wday_reg, wday_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  day_reg, day_next;

    logic [24:0] mul_a;
    logic [25:0] mul_b;
    logic [50:0] product;
    logic [15:0] quo_calc;
    logic [16:0] dvs;
    logic [31:0] back_prod;
    logic [31:0] rem_step;
    logic        leap;
    logic [8:0]  ylen;
    logic [4:0]  mlen;
    logic        year_done;
    logic        month_done;

    // Quotients come from a multiply by a rounded-up reciprocal and a shift. The
    // divisor's factor of two is shifted off the numerator first, which keeps the
    // quotient exact over the whole numerator range of each phase.
    always_comb
    begin
        unique case (cmd.div_sel)
            DIV_DAY:
            begin
                mul_a = rem_reg[31:7];
                mul_b = DAY_RECIP;
                dvs   = SECS_PER_DAY;
            end
            DIV_HOUR:
            begin
                mul_a = {12'd0, rem_reg[16:4]};
                mul_b = HOUR_RECIP;
                dvs   = SECS_PER_HOUR;
            end
            DIV_MIN:
            begin
                mul_a = {15'd0, rem_reg[11:2]};
                mul_b = MIN_RECIP;
                dvs   = SECS_PER_MIN;
            end
            DIV_WDAY:
            begin
                mul_a = {9'd0, rem_reg[15:0]};
                mul_b = WDAY_RECIP;
                dvs   = DAYS_PER_WEEK;
            end
        endcase
        product = mul_a * mul_b;
        unique case (cmd.div_sel)
            DIV_DAY:  quo_calc = product[50:35];
            DIV_HOUR: quo_calc = product[36:21];
            DIV_MIN:  quo_calc = product[29:14];
            DIV_WDAY: quo_calc = product[34:19];
        endcase
    end

    // The remainder step uses the quotient registered in the step before.
    assign back_prod = {16'd0, quo_reg} * {15'd0, dvs};
    assign rem_step  = rem_reg - back_prod;

    // Gregorian rule: every fourth year, except centuries not divisible by 400.
    assign leap = ((mod400_reg[1:0] == 2'b00) && (mod100_reg != '0)) || (mod400_reg == '0);
    assign ylen = leap ? DAYS_LEAP_YEAR : DAYS_COMMON_YEAR;
    assign mlen = month_len(mon_idx_reg, leap);

    assign year_done  = (cday_reg < {7'd0, ylen});
    assign month_done = (mon_idx_reg == MONTH_LAST) || (cday_reg < {11'd0, mlen});

    always_comb
    begin
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        days_next    = days_reg;
        cday_next    = cday_reg;
        year_next    = year_reg;
        mod400_next  = mod400_reg;
        mod100_next  = mod100_reg;
        mon_idx_next = mon_idx_reg;
        hour_next    = hour_reg;
        min_next     = min_reg;
        sec_next     = sec_reg;
        ms_next      = ms_reg;
        wday_next    = wday_reg;
        month_next   = month_reg;
        day_next     = day_reg;

        if (cmd.load)
        begin
            rem_next = whole_seconds;
            quo_next = '0;
            ms_next  = (millis_in >= MS_PER_SEC) ? (millis_in - MS_PER_SEC) : millis_in;
        end

        if (cmd.div_step)
        begin
            if (!cmd.div_last)
            begin
                quo_next = quo_calc;
            end
            else
            begin
                rem_next = rem_step;
                unique case (cmd.div_sel)
                    DIV_DAY:
                    begin
                        days_next = quo_reg;
                    end
                    DIV_HOUR:
                    begin
                        hour_next = quo_reg[4:0];
                    end
                    DIV_MIN:
                    begin
                        min_next = quo_reg[5:0];
                        sec_next = rem_step[5:0];
                        rem_next = {16'd0, days_reg + EPOCH_WEEKDAY};
                    end
                    DIV_WDAY:
                    begin
                        wday_next    = rem_step[2:0];
                        cday_next    = days_reg;
                        year_next    = EPOCH_YEAR;
                        mod400_next  = EPOCH_MOD400;
                        mod100_next  = EPOCH_MOD100;
                        mon_idx_next = '0;
                    end
                endcase
            end
        end

        if (cmd.year_step && !year_done)
        begin
            cday_next   = cday_reg - {7'd0, ylen};
            year_next   = year_reg + 1'b1;
            mod400_next = (mod400_reg == MOD400_LAST) ? '0 : (mod400_reg + 1'b1);
            mod100_next = (mod100_reg == MOD100_LAST) ? '0 : (mod100_reg + 1'b1);
        end

        if (cmd.month_step && !month_done)
        begin
            cday_next    = cday_reg - {11'd0, mlen};
            mon_idx_next = mon_idx_reg + 1'b1;
        end

        if (cmd.finish)
        begin
            month_next = mon_idx_reg + 1'b1;
            day_next   = cday_reg[4:0] + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        days_reg    <= days_next;
        cday_reg    <= cday_next;
        year_reg    <= year_next;
        mod400_reg  <= mod400_next;
        mod100_reg  <= mod100_next;
        mon_idx_reg <= mon_idx_next;
        hour_reg    <= hour_next;
        min_reg     <= min_next;
        sec_reg     <= sec_next;
        ms_reg      <= ms_next;
        wday_reg    <= wday_next;
        month_reg   <= month_next;
        day_reg     <= day_next;
    end

    assign status.year_done  = year_done;
    assign status.month_done = month_done;

    assign year       = year_reg;
    assign month      = month_reg;
    assign day        = day_reg;
    assign hour       = hour_reg;
    assign minute     = min_reg;
    assign second_out = sec_reg;
    assign millis_out = ms_reg;
    assign weekday    = wday_reg;

endmodule

FILE: src/es2cal_checker.sv
// Port-level checks of the date converter and their binding to the top level.
`include "assert_macros.svh"

module es2cal_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [3:0] month,
    input logic [4:0] day,
    input logic [2:0] weekday,
    input logic [9:0] millis_out
);

    logic fields_ok;

    assign fields_ok = (month != 4'd0) && (month <= 4'd12) && (day != 5'd0)
                       && (weekday <= 3'd6) && (millis_out <= 10'd999);

    // An accepted transaction keeps the block busy in the next cycle.
    `ES_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // A result is shown only once the block has gone idle.
    `ES_ASSERT_IMP(a_done_idle, done, !busy)
    // Busy ends only by delivering a result.
    `ES_ASSERT_IMP(a_busy_end, $fell(busy), done)
    // The result strobe lasts one cycle.
    `ES_ASSERT_NEXT(a_done_pulse, done, !done)
    // Delivered fields stay within their calendar ranges.
    `ES_ASSERT_IMP(a_result_range, done, fields_ok)

endmodule

bind epoch_seconds_to_calendar_date es2cal_checker u_checker (.*);
